>>> design/rbj_pkg.sv
// ----------------------------------------------------------------------------
// rbj_pkg: shared types, constants and delay tables for the backoff timer
// Holds the request and response layouts, action codes and the per-exponent
// delay constants (cap floor and jitter span).
// ----------------------------------------------------------------------------
`default_nettype none

package rbj_pkg;

  localparam int TIME_WIDTH  = 48;
  localparam int NEXT_WIDTH  = TIME_WIDTH + 1;
  localparam int RND_WIDTH   = 32;
  localparam int DELAY_WIDTH = 16;
  localparam int SUM_WIDTH   = DELAY_WIDTH + 1;
  localparam int SPAN_WIDTH  = 14;
  localparam int PROD_WIDTH  = 26;
  localparam int COUNT_WIDTH = 3;
  localparam int STEP_WIDTH  = 5;

  localparam logic [1:0] ACT_RESET = 2'd0;
  localparam logic [1:0] ACT_FAIL  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = 3'd7;
  localparam logic [COUNT_WIDTH-1:0] MAX_EXPONENT = 3'd6;
  localparam logic [SUM_WIDTH-1:0]   MAX_DELAY_MS = 17'd60000;
  localparam logic [9:0]             US_PER_MS    = 10'd1000;
  localparam logic [STEP_WIDTH-1:0]  LAST_STEP    = 5'd31;

  typedef struct packed {
    logic [1:0]            action;
    logic [TIME_WIDTH-1:0] now_us;
    logic [RND_WIDTH-1:0]  jitter_seed;
  } req_t;

  typedef struct packed {
    logic [DELAY_WIDTH-1:0] backoff_ms;
    logic                   attempt_due;
  } rsp_t;

  // Capped base delay in ms for a failure count
  function automatic logic [DELAY_WIDTH-1:0] cap_of(input logic [COUNT_WIDTH-1:0] count);
    logic [DELAY_WIDTH-1:0] cap;
    case (count)
      3'd0:    cap = 16'd1000;
      3'd1:    cap = 16'd2000;
      3'd2:    cap = 16'd4000;
      3'd3:    cap = 16'd8000;
      3'd4:    cap = 16'd16000;
      3'd5:    cap = 16'd32000;
      default: cap = 16'd60000;
    endcase
    return cap;
  endfunction

  // Jitter modulus: cap/4 + 1
  function automatic logic [SPAN_WIDTH-1:0] span_of(input logic [COUNT_WIDTH-1:0] count);
    logic [DELAY_WIDTH-1:0] cap;
    cap = cap_of(count);
    return SPAN_WIDTH'(cap[DELAY_WIDTH-1:2]) + SPAN_WIDTH'(1);
  endfunction

  // Lowest delay: cap - cap/8
  function automatic logic [DELAY_WIDTH-1:0] floor_of(input logic [COUNT_WIDTH-1:0] count);
    logic [DELAY_WIDTH-1:0] cap;
    cap = cap_of(count);
    return cap - {3'b000, cap[DELAY_WIDTH-1:3]};
  endfunction

endpackage

`default_nettype wire

>>> design/rbj_mod_unit.sv
// ----------------------------------------------------------------------------
// rbj_mod_unit: serial remainder unit
// Restoring shift-subtract remainder of a 32-bit word by a 14-bit modulus,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbj_mod_unit import rbj_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [RND_WIDTH-1:0]  dividend,
  input  wire logic [SPAN_WIDTH-1:0] divisor,
  output logic                       done,
  output logic [SPAN_WIDTH-1:0]      remainder
);

  logic                  run;
  logic [STEP_WIDTH-1:0] step;
  logic [RND_WIDTH-1:0]  dvd;
  logic [SPAN_WIDTH-1:0] dsr;
  logic [SPAN_WIDTH-1:0] rem;
  logic [SPAN_WIDTH:0]   shifted;
  logic [SPAN_WIDTH:0]   trial;
  logic [SPAN_WIDTH-1:0] rem_next;

  // Shift in next dividend bit and subtract when it fits
  always_comb begin
    shifted = {rem, dvd[RND_WIDTH-1]};
    trial   = shifted - {1'b0, dsr};
    if (shifted >= {1'b0, dsr}) begin
      rem_next = trial[SPAN_WIDTH-1:0];
    end else begin
      rem_next = shifted[SPAN_WIDTH-1:0];
    end
  end

  // Advance one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= run && !start && (step == LAST_STEP);
      if (start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + STEP_WIDTH'(1);
        if (step == LAST_STEP) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[RND_WIDTH-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

`default_nettype wire

>>> design/retry_backoff_jitter_timer.sv
// ----------------------------------------------------------------------------
// retry_backoff_jitter_timer: exponential retry backoff with random jitter
// Sequencer around a serial remainder unit; keeps the failure count and
// the next attempt time, answers one response per request.
// ----------------------------------------------------------------------------
//  channel | signals                  | direction
//  --------+--------------------------+----------
//  req     | req_valid, req_stall, req| in
//  rsp     | rsp_valid, rsp_stall, rsp| out
//
//  Failure: the 32 remainder steps and the done pickup run in S_DIV, then
//  clamp, multiply by 1000, add and load run in S_CLAMP, S_MUL, S_ADD and
//  S_FIN; the next request is taken back in S_IDLE. Reset and query go from
//  S_IDLE straight to S_FIN, where the response loads. Requests are taken
//  only while idle; a stalled response holds the next result in its final state.
//  Reset (rst, synchronous) clears failure count and next attempt time.
// ----------------------------------------------------------------------------
`default_nettype none

module retry_backoff_jitter_timer import rbj_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CLAMP,
    S_MUL,
    S_ADD,
    S_FIN
  } state_t;

  state_t                 state;
  req_t                   cur;
  logic [COUNT_WIDTH-1:0] fail_count;
  logic [NEXT_WIDTH-1:0]  next_attempt_time;
  logic [DELAY_WIDTH-1:0] delay;
  logic [PROD_WIDTH-1:0]  prod;

  logic                   accept;
  logic                   mod_start;
  logic                   mod_done;
  logic [SPAN_WIDTH-1:0]  mod_rem;
  logic [SUM_WIDTH-1:0]   sum;
  logic [SUM_WIDTH-1:0]   delay_next;
  logic                   due;
  logic                   out_free;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign mod_start = accept && (req.action == ACT_FAIL);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Jitter remainder over the span for the current failure count
  rbj_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (req.jitter_seed),
    .divisor   (span_of(fail_count)),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Add jitter to floor and clamp to the maximum delay
  always_comb begin
    sum = SUM_WIDTH'(floor_of(fail_count)) + SUM_WIDTH'(mod_rem);
    if (sum > MAX_DELAY_MS) begin
      delay_next = MAX_DELAY_MS;
    end else begin
      delay_next = sum;
    end
  end

  // Query compare against the schedule
  assign due = ({1'b0, cur.now_us} >= next_attempt_time);

  // Sequencer, state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      fail_count        <= '0;
      next_attempt_time <= '0;
      rsp_valid         <= 1'b0;
    end else begin
      // Raise valid when a result loads, drop it once taken
      if ((state == S_FIN) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur   <= req;
            delay <= '0;
            if (req.action == ACT_FAIL) begin
              state <= S_DIV;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          delay <= delay_next[DELAY_WIDTH-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_WIDTH'(delay) * PROD_WIDTH'(US_PER_MS);
          state <= S_ADD;
        end
        S_ADD: begin
          next_attempt_time <= NEXT_WIDTH'(cur.now_us) + NEXT_WIDTH'(prod);
          if (fail_count != COUNT_MAX) begin
            fail_count <= fail_count + COUNT_WIDTH'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp.backoff_ms  <= delay;
            rsp.attempt_due <= (cur.action == ACT_QUERY) && due;
            if (cur.action == ACT_RESET) begin
              fail_count        <= '0;
              next_attempt_time <= NEXT_WIDTH'(cur.now_us);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the retry backoff jitter timer
// Drives reset, failure, query and unused-action requests through the
// valid/stall request channel and predicts each response from a local model
// of the failure count and the next attempt time. Both sides idle at random,
// and the response side holds off for a long stretch at least once.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rbj_pkg::*;

  localparam logic [1:0]            ACT_UNUSED    = 2'd3;
  localparam int unsigned           BASE_DELAY_MS = 1000;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX      = '1;
  localparam int                    RANDOM_ITEMS  = 1100;
  localparam int                    REPORT_LIMIT  = 10;
  localparam int                    HOLD_CYCLES   = 400;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Model state of the timer
  logic [COUNT_WIDTH-1:0] fail_cnt    = '0;
  logic [NEXT_WIDTH-1:0]  next_due_us = '0;

  rsp_t expected_replies[$];
  rsp_t oldest_reply;
  int   error_count = 0;
  bit   idle_en     = 1'b1;
  bit   hold_go     = 1'b0;
  bit   hold_seen   = 1'b0;
  int   hold_left   = 0;

  retry_backoff_jitter_timer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the response to one request and advance the model state
  function automatic rsp_t predict_backoff(input req_t item);
    rsp_t        res;
    int unsigned exponent;
    int unsigned cap_ms;
    int unsigned span_ms;
    int unsigned delay;
    res = '0;
    case (item.action)
      ACT_RESET: begin
        fail_cnt    = '0;
        next_due_us = {1'b0, item.now_us};
      end
      ACT_FAIL: begin
        exponent = 32'((fail_cnt > MAX_EXPONENT) ? MAX_EXPONENT : fail_cnt);
        cap_ms   = BASE_DELAY_MS << exponent;
        if (cap_ms > MAX_DELAY_MS) cap_ms = 32'(MAX_DELAY_MS);
        span_ms  = cap_ms / 4 + 1;
        delay    = cap_ms - cap_ms / 8 + item.jitter_seed % span_ms;
        if (delay > MAX_DELAY_MS) delay = 32'(MAX_DELAY_MS);
        if (fail_cnt != COUNT_MAX) fail_cnt = fail_cnt + 1'b1;
        // Schedule is one bit wider than the timestamp, so it never wraps
        next_due_us    = {1'b0, item.now_us} + NEXT_WIDTH'(delay) * NEXT_WIDTH'(US_PER_MS);
        res.backoff_ms = delay[DELAY_WIDTH-1:0];
      end
      ACT_QUERY: begin
        res.attempt_due = ({1'b0, item.now_us} >= next_due_us);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] act,
                                    input logic [TIME_WIDTH-1:0] now,
                                    input logic [RND_WIDTH-1:0] rnd);
    req_t item;
    item.action      = act;
    item.now_us      = now;
    item.jitter_seed = rnd;
    return item;
  endfunction

  // Pick a timestamp: mostly close to the schedule, some anywhere, some extremes
  function automatic logic [TIME_WIDTH-1:0] pick_now();
    logic [63:0]           wide;
    logic [NEXT_WIDTH-1:0] near;
    int unsigned           sel;
    int unsigned           offset;
    sel    = $urandom_range(0, 99);
    wide   = {$urandom, $urandom};
    offset = $urandom_range(0, 3000);
    if (sel < 30) return wide[TIME_WIDTH-1:0];
    if (sel < 38) return sel[0] ? TIME_MAX : '0;
    if (sel < 48) near = next_due_us;
    else if (sel < 74) near = next_due_us + NEXT_WIDTH'(offset);
    else near = (next_due_us > offset) ? next_due_us - NEXT_WIDTH'(offset) : '0;
    if (near[TIME_WIDTH]) return TIME_MAX;
    return near[TIME_WIDTH-1:0];
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Offer one request from a falling edge; predict its response on acceptance
  task automatic send_request(input req_t item);
    bit          taken;
    logic [95:0] noise;
    taken = 1'b0;
    while (idle_en && $urandom_range(0, 99) < 28) begin
      noise     = {$urandom, $urandom, $urandom};
      req_valid = 1'b0;
      req       = noise[$bits(req_t)-1:0];
      @(negedge clk);
    end
    req_valid = 1'b1;
    req       = item;
    while (!taken) begin
      @(posedge clk);
      if (!req_stall) begin
        taken = 1'b1;
        expected_replies.push_back(predict_backoff(item));
      end
      @(negedge clk);
    end
  endtask

  // Stall the response side: long hold-off when asked, else random
  always @(negedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      rsp_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      rsp_stall = idle_en && ($urandom_range(0, 99) < 28);
    end
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (expected_replies.size() == 0) begin
        note_failure($sformatf("unexpected response backoff_ms=%0d attempt_due=%0b",
                               rsp.backoff_ms, rsp.attempt_due));
      end else begin
        oldest_reply = expected_replies.pop_front();
        if (rsp.backoff_ms !== oldest_reply.backoff_ms)
          note_failure($sformatf("backoff_ms expected %0d got %0d",
                                 oldest_reply.backoff_ms, rsp.backoff_ms));
        if (rsp.attempt_due !== oldest_reply.attempt_due)
          note_failure($sformatf("attempt_due expected %0b got %0b",
                                 oldest_reply.attempt_due, rsp.attempt_due));
      end
    end
  end

  // Query right after reset, at the largest time, and around a reset point
  task automatic test_reset_and_query();
    send_request(make_req(ACT_QUERY, '0, '0));
    send_request(make_req(ACT_QUERY, TIME_MAX, '1));
    send_request(make_req(ACT_RESET, 48'h1234_5678_9ABC, $urandom));
    send_request(make_req(ACT_QUERY, 48'h1234_5678_9ABB, $urandom));
    send_request(make_req(ACT_QUERY, 48'h1234_5678_9ABC, $urandom));
  endtask

  // Walk the failure count up to saturation, covering jitter floor and clamp
  task automatic test_failure_ladder();
    logic [RND_WIDTH-1:0] jitter[8] = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd2000,
                                        32'd4000, 32'd8000, 32'd15000, 32'd15000};
    send_request(make_req(ACT_RESET, '0, '0));
    for (int k = 0; k < 8; k++)
      send_request(make_req(ACT_FAIL, TIME_WIDTH'(k) * 48'd5_000_000, jitter[k]));
    send_request(make_req(ACT_QUERY, next_due_us[TIME_WIDTH-1:0] - 1'b1, $urandom));
    send_request(make_req(ACT_QUERY, next_due_us[TIME_WIDTH-1:0], $urandom));
  endtask

  // Schedule past the largest timestamp; a query never reaches it
  task automatic test_late_schedule();
    send_request(make_req(ACT_RESET, TIME_MAX, $urandom));
    send_request(make_req(ACT_FAIL, TIME_MAX, $urandom));
    send_request(make_req(ACT_QUERY, TIME_MAX, $urandom));
  endtask

  // Unused action leaves the state alone
  task automatic test_unused_action();
    send_request(make_req(ACT_UNUSED, TIME_MAX, '1));
    send_request(make_req(ACT_UNUSED, '0, '0));
    send_request(make_req(ACT_QUERY, TIME_MAX, $urandom));
  endtask

  task automatic send_random_request();
    int unsigned          pick;
    logic [1:0]           act;
    logic [RND_WIDTH-1:0] rnd;
    pick = $urandom_range(0, 99);
    if (pick < 8) act = ACT_RESET;
    else if (pick < 48) act = ACT_FAIL;
    else if (pick < 95) act = ACT_QUERY;
    else act = ACT_UNUSED;
    rnd = ($urandom_range(0, 9) == 0) ? RND_WIDTH'($urandom_range(0, 15001)) : $urandom;
    send_request(make_req(act, pick_now(), rnd));
  endtask

  // Random traffic, with a long stretch where neither side idles
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en = !(i >= 400 && i < 600);
      send_random_request();
    end
    idle_en = 1'b1;
  endtask

  // Hold off the response side while requests keep coming
  task automatic test_backpressure();
    hold_go = 1'b1;
    repeat (30) send_random_request();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_and_query();
    test_failure_ladder();
    test_late_schedule();
    test_unused_action();
    test_random_traffic();
    test_backpressure();
    req_valid = 1'b0;
    // Drain outstanding responses, then give the block time to go quiet
    wait (expected_replies.size() == 0);
    repeat (60) @(posedge clk);
    if (expected_replies.size() != 0)
      note_failure($sformatf("%0d responses never arrived", expected_replies.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
